// ----- hdl/mfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter frame receiver package
// Shared constants, codes and types for the meter frame receiver.
// ----------------------------------------------------------------------------
package mfr_pkg;

  localparam int unsigned Q_DEPTH = 2;

  localparam logic [7:0] START_BYTE   = 8'h68;
  localparam logic [7:0] END_BYTE     = 8'h16;
  localparam int unsigned RESP_BIT    = 7;
  localparam logic [8:0] CTRL_OFFSET  = 9'd9;
  localparam logic [8:0] LEN_OFFSET   = 9'd10;
  localparam logic [8:0] CSUM_GAP     = 9'd11;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CHECKSUM = 3'd1;
  localparam logic [2:0] ST_NO_END   = 3'd2;
  localparam logic [2:0] ST_ZERO_LEN = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;
  localparam logic [2:0] ST_NOT_RESP = 3'd5;

  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_REQ_RESP = 2'd1;
  localparam logic [1:0] REG_REJ_ZERO = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd100;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       is_start;
    logic       is_end;
    logic       is_zero;
  } class_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic        require_response;
    logic        reject_zero_length;
  } cfg_t;

endpackage

// ----- hdl/mfr_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter frame receiver channels
// Valid/ready channels for received words and for frame results.
// ----------------------------------------------------------------------------
interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface mfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [8:0] byte_offset;
  logic       frame_end;
  logic [2:0] status;

  modport source (output valid, output frame_byte, output byte_offset,
                  output frame_end, output status, input ready);
  modport sink (input valid, input frame_byte, input byte_offset,
                input frame_end, input status, output ready);
endinterface

// ----- hdl/mfr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter frame receiver front end
// Registers incoming words and tags start, end and zero bytes.
// ----------------------------------------------------------------------------
module mfr_front (
  input  logic           clk,
  input  logic           rst_n,
  mfr_in_if.sink         in_ch,
  output mfr_pkg::class_t item,
  output logic           item_valid,
  input  logic           item_ready
);
  import mfr_pkg::*;

  logic   valid_r;
  class_t item_r;
  logic   take;

  assign in_ch.ready = !valid_r || item_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign item        = item_r;
  assign item_valid  = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.cmd      <= in_ch.cmd;
      item_r.data     <= in_ch.rx_byte;
      item_r.is_start <= (in_ch.rx_byte == START_BYTE);
      item_r.is_end   <= (in_ch.rx_byte == END_BYTE);
      item_r.is_zero  <= (in_ch.rx_byte == 8'd0);
    end
  end

endmodule

// ----- hdl/mfr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter frame receiver queue
// Short first-in first-out queue of tagged words between front and back.
// ----------------------------------------------------------------------------
module mfr_queue #(
  parameter int unsigned DEPTH = mfr_pkg::Q_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mfr_pkg::class_t push_item,
  input  logic            push_valid,
  output logic            push_ready,
  output mfr_pkg::class_t pop_item,
  output logic            pop_valid,
  input  logic            pop_ready
);
  import mfr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  class_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- hdl/mfr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter frame receiver back end
// Frame state, checksum and verdicts, with the result register.
// ----------------------------------------------------------------------------
module mfr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mfr_pkg::cfg_t   cfg,
  input  mfr_pkg::class_t item,
  input  logic            item_valid,
  output logic            item_ready,
  mfr_out_if.source       out_ch
);
  import mfr_pkg::*;

  logic        phase_r, phase_nxt;
  logic [8:0]  count_r, count_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        resp_r, resp_nxt;
  logic [15:0] wait_r, wait_nxt;

  logic        ovalid_r;
  logic [7:0]  obyte_r, obyte_nxt;
  logic [8:0]  ooff_r, ooff_nxt;
  logic        oend_r, oend_nxt;
  logic [2:0]  ostat_r, ostat_nxt;
  logic        emit;
  logic        pop;
  logic [7:0]  len_eff;
  logic [8:0]  csum_off;

  assign item_ready = !ovalid_r || out_ch.ready;
  assign pop        = item_valid && item_ready;

  assign out_ch.valid       = ovalid_r;
  assign out_ch.frame_byte  = obyte_r;
  assign out_ch.byte_offset = ooff_r;
  assign out_ch.frame_end   = oend_r;
  assign out_ch.status      = ostat_r;

  assign len_eff  = (count_r == LEN_OFFSET) ? item.data : len_r;
  assign csum_off = {1'b0, len_eff} + CSUM_GAP;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    resp_nxt  = resp_r;
    wait_nxt  = wait_r;
    emit      = 1'b0;
    obyte_nxt = item.data;
    ooff_nxt  = count_r;
    oend_nxt  = 1'b0;
    ostat_nxt = ST_OK;
    if (!phase_r) begin
      if (item.cmd == CMD_BYTE && item.is_start) begin
        phase_nxt = 1'b1;
        count_nxt = 9'd1;
        sum_nxt   = item.data;
        wait_nxt  = '0;
        len_nxt   = '0;
        resp_nxt  = 1'b0;
        emit      = 1'b1;
        ooff_nxt  = '0;
      end
    end else if (item.cmd == CMD_TICK) begin
      if (wait_r < cfg.timeout_ticks) begin
        wait_nxt = wait_r + 16'd1;
      end else begin
        wait_nxt  = '0;
        phase_nxt = 1'b0;
        emit      = 1'b1;
        obyte_nxt = '0;
        oend_nxt  = 1'b1;
        ostat_nxt = ST_TIMEOUT;
      end
    end else begin
      emit = 1'b1;
      if (count_r == CTRL_OFFSET) begin
        resp_nxt = item.data[RESP_BIT];
      end
      if (count_r == LEN_OFFSET) begin
        len_nxt = item.data;
      end
      if (count_r == LEN_OFFSET && item.is_zero && cfg.reject_zero_length) begin
        phase_nxt = 1'b0;
        oend_nxt  = 1'b1;
        ostat_nxt = ST_ZERO_LEN;
      end else if (count_r < csum_off) begin
        sum_nxt   = sum_r + item.data;
        count_nxt = count_r + 9'd1;
      end else if (count_r == csum_off) begin
        sum_nxt   = sum_r - item.data;
        count_nxt = count_r + 9'd1;
      end else begin
        phase_nxt = 1'b0;
        oend_nxt  = 1'b1;
        if (!item.is_end) begin
          ostat_nxt = ST_NO_END;
        end else if (cfg.require_response && !resp_r) begin
          ostat_nxt = ST_NOT_RESP;
        end else if (sum_r != 8'd0) begin
          ostat_nxt = ST_CHECKSUM;
        end else begin
          ostat_nxt = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      count_r  <= '0;
      len_r    <= '0;
      sum_r    <= '0;
      resp_r   <= 1'b0;
      wait_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        len_r   <= len_nxt;
        sum_r   <= sum_nxt;
        resp_r  <= resp_nxt;
        wait_r  <= wait_nxt;
      end
      if (item_ready) begin
        ovalid_r <= pop && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      obyte_r <= obyte_nxt;
      ooff_r  <= ooff_nxt;
      oend_r  <= oend_nxt;
      ostat_r <= ostat_nxt;
    end
  end

endmodule

// ----- hdl/meter_frame_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter frame receiver
// Deframes meter bus frames from received words and timeout ticks.
// ----------------------------------------------------------------------------
//  Port     Direction  Carries
//  in_ch    sink       cmd, rx_byte: one received byte or one timeout tick
//  out_ch   source     frame_byte, byte_offset, frame_end, status
//  APB      slave      timeout_ticks, require_response, reject_zero_length
//
//  The frame state update sustains one word per cycle while results are taken.
//  A word passes the front register and queue to reach the result register.
//  Reset is synchronous and returns the block to hunting for a start byte.
//  A stalled result holds the back end; the queue lets the front keep taking
//  words until it fills.
// ----------------------------------------------------------------------------
module meter_frame_receiver #(
  parameter int unsigned QUEUE_DEPTH = mfr_pkg::Q_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mfr_in_if.sink                     in_ch,
  mfr_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mfr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import mfr_pkg::*;

  cfg_t   cfg_r;
  class_t f_item, q_item;
  logic   f_valid, f_ready, q_valid, q_ready;
  logic   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks      <= TIMEOUT_RST;
      cfg_r.require_response   <= 1'b1;
      cfg_r.reject_zero_length <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_TIMEOUT:  cfg_r.timeout_ticks      <= pwdata[15:0];
        REG_REQ_RESP: cfg_r.require_response   <= pwdata[0];
        REG_REJ_ZERO: cfg_r.reject_zero_length <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TIMEOUT:  prdata = {16'd0, cfg_r.timeout_ticks};
      REG_REQ_RESP: prdata = {31'd0, cfg_r.require_response};
      REG_REJ_ZERO: prdata = {31'd0, cfg_r.reject_zero_length};
      default:      prdata = '0;
    endcase
  end

  mfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  mfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (f_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_item   (q_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  mfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (q_item),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .out_ch     (out_ch)
  );

endmodule

// ----- tb/meter_frame_receiver_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter frame receiver testbench
// Feeds received bytes and timeout ticks through the input channel, mostly as
// well-formed meter frames with random content, broken frames and line noise,
// under several register settings and idle patterns. A deframing predictor
// computes the expected frame words, and each word on the result channel is
// compared with the oldest expected one.
// ----------------------------------------------------------------------------
module meter_frame_receiver_tb;
  import mfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } line_word_t;

  typedef struct packed {
    logic [7:0] fbyte;
    logic [8:0] offs;
    logic       fend;
    logic [2:0] st;
  } frame_echo_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mfr_in_if  in_ch ();
  mfr_out_if out_ch ();

  meter_frame_receiver u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  line_word_t  line_q[$];
  frame_echo_t echo_q[$];
  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned frame_words;
  int unsigned errors;
  int unsigned cycles;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  logic [15:0] m_timeout;
  logic        m_req_resp;
  logic        m_rej_zero;

  logic        in_frame;
  logic [8:0]  next_off;
  logic [7:0]  frame_len;
  logic [7:0]  csum;
  logic        resp_seen;
  logic [15:0] tick_count;

  always #4 clk = ~clk;

  task automatic flag_mismatch(input string what, input frame_echo_t got,
                               input frame_echo_t want);
    errors++;
    $display({"[%0t] %s: got byte %02h off %0d end %0b st %0d, ",
              "want byte %02h off %0d end %0b st %0d"},
             $realtime, what, got.fbyte, got.offs, got.fend, got.st,
             want.fbyte, want.offs, want.fend, want.st);
  endtask

  task automatic deframe_word(input logic cmd, input logic [7:0] b);
    logic [8:0] off;
    logic [8:0] csum_at;
    logic [2:0] st;
    if (!in_frame) begin
      if (cmd == CMD_BYTE && b == START_BYTE) begin
        in_frame = 1'b1;
        next_off = 9'd1;
        csum = b;
        tick_count = '0;
        frame_len = '0;
        resp_seen = 1'b0;
        echo_q.push_back('{b, 9'd0, 1'b0, ST_OK});
      end
      return;
    end
    if (cmd == CMD_TICK) begin
      if (tick_count < m_timeout) begin
        tick_count = tick_count + 16'd1;
      end else begin
        tick_count = '0;
        in_frame = 1'b0;
        echo_q.push_back('{8'h00, next_off, 1'b1, ST_TIMEOUT});
      end
      return;
    end
    off = next_off;
    if (off == CTRL_OFFSET) resp_seen = b[RESP_BIT];
    if (off == LEN_OFFSET) begin
      frame_len = b;
      if (b == 8'h00 && m_rej_zero) begin
        in_frame = 1'b0;
        echo_q.push_back('{b, off, 1'b1, ST_ZERO_LEN});
        return;
      end
    end
    csum_at = {1'b0, frame_len} + CSUM_GAP;
    if (off < CSUM_GAP || off < csum_at) begin
      csum = csum + b;
    end else if (off == csum_at) begin
      csum = csum - b;
    end else begin
      if (b != END_BYTE) st = ST_NO_END;
      else if (m_req_resp && !resp_seen) st = ST_NOT_RESP;
      else if (csum != 8'h00) st = ST_CHECKSUM;
      else st = ST_OK;
      in_frame = 1'b0;
      echo_q.push_back('{b, off, 1'b1, st});
      return;
    end
    next_off = off + 9'd1;
    echo_q.push_back('{b, off, 1'b0, ST_OK});
  endtask

  task automatic add_word(input logic cmd, input logic [7:0] b);
    line_q.push_back('{cmd, b});
    words_queued++;
  endtask

  task automatic add_ticks(input int unsigned tick_pct);
    int unsigned burst;
    int unsigned top;
    if ($urandom_range(0, 99) < tick_pct) begin
      top = (m_timeout > 22) ? 24 : m_timeout + 2;
      burst = $urandom_range(1, top);
      repeat (burst) add_word(CMD_TICK, 8'($urandom_range(0, 255)));
      frame_words += burst;
    end
  endtask

  // keep = 0 sends the whole frame, otherwise only its first keep bytes.
  task automatic add_frame(input int unsigned len, input logic [7:0] ctrl,
                           input bit bad_sum, input bit bad_end,
                           input int unsigned keep, input int unsigned tick_pct);
    logic [7:0] body[$];
    logic [7:0] sum;
    logic [7:0] tail;
    int unsigned n;
    body.push_back(START_BYTE);
    repeat (8) body.push_back(8'($urandom_range(0, 255)));
    body.push_back(ctrl);
    body.push_back(len[7:0]);
    repeat (len) body.push_back(8'($urandom_range(0, 255)));
    sum = '0;
    foreach (body[i]) sum = sum + body[i];
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    body.push_back(sum);
    tail = END_BYTE;
    if (bad_end) begin
      tail = 8'($urandom_range(0, 255));
      if (tail == END_BYTE) tail[0] = ~tail[0];
    end
    body.push_back(tail);
    n = (keep == 0 || keep > body.size()) ? body.size() : keep;
    for (int i = 0; i < n; i++) begin
      if (i > 0) add_ticks(tick_pct);
      add_word(CMD_BYTE, body[i]);
      frame_words++;
    end
  endtask

  task automatic add_traffic(input int unsigned target, input bit with_longest);
    int unsigned start;
    int unsigned len;
    logic [7:0] ctrl;
    int unsigned keep;
    if (with_longest) add_frame(255, 8'h80 | 8'($urandom_range(0, 127)), 0, 0, 0, 0);
    start = frame_words;
    while (frame_words - start < target) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          add_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
      end else begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        ctrl = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) != 0) ctrl[RESP_BIT] = 1'b1;
        keep = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len + 12) : 0;
        add_frame(len, ctrl, $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 12,
                  keep, 4);
      end
    end
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] tmo, input logic req, input logic rej);
    apb_write(REG_TIMEOUT, {16'h0000, tmo});
    m_timeout = tmo;
    apb_write(REG_REQ_RESP, {31'd0, req});
    m_req_resp = req;
    apb_write(REG_REJ_ZERO, {31'd0, rej});
    m_rej_zero = rej;
  endtask

  task automatic drain();
    while (!(words_taken == words_queued && echo_q.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (line_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        line_word_t w;
        w = line_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= w.cmd;
        in_ch.rx_byte <= w.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      deframe_word(in_ch.cmd, in_ch.rx_byte);
      words_taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    frame_echo_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.frame_byte, out_ch.byte_offset, out_ch.frame_end, out_ch.status};
      if (echo_q.size() == 0) begin
        flag_mismatch("unexpected word", got, '0);
      end else if (got !== echo_q[0]) begin
        flag_mismatch("mismatch", got, echo_q.pop_front());
      end else begin
        void'(echo_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("meter_frame_receiver_tb NOT OK");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_BYTE;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    words_queued = 0;
    words_taken = 0;
    frame_words = 0;
    errors = 0;
    cycles = 0;
    src_idle_pct = 31;
    snk_idle_pct = 48;
    m_timeout = TIMEOUT_RST;
    m_req_resp = 1'b1;
    m_rej_zero = 1'b1;
    in_frame = 1'b0;
    next_off = '0;
    frame_len = '0;
    csum = '0;
    resp_seen = 1'b0;
    tick_count = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: line noise while hunting, a good frame and a zero length frame.
    add_word(CMD_BYTE, 8'h00);
    add_word(CMD_TICK, 8'hFF);
    add_word(CMD_BYTE, 8'hFF);
    add_frame(1, 8'h81, 0, 0, 0, 0);
    add_frame(0, 8'h80, 0, 0, 0, 0);
    drain();

    for (int ph = 1; ph <= 5; ph++) begin
      if (ph == 2) begin
        src_idle_pct = 48;
        snk_idle_pct = 31;
      end else if (ph == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case (ph)
        1: configure(16'd0, 1'b0, 1'b0);
        2: configure(16'hFFFF, 1'b1, 1'b1);
        3: configure(16'd3, 1'b1, 1'b0);
        4: configure(16'd1, 1'b0, 1'b1);
        default: configure(16'd20, 1'b1, 1'b1);
      endcase
      add_traffic(60, ph == 3);
      drain();
    end

    if (errors == 0) begin
      $display("meter_frame_receiver_tb OK");
    end else begin
      $display("meter_frame_receiver_tb NOT OK");
    end
    $finish;
  end

endmodule
